/* sv/pidpi_pkg.sv */
// ----------------------------------------------------------------------------
// pidpi_pkg
// shared widths, register indexes and the configuration bundle of the pid core
// ----------------------------------------------------------------------------
`default_nettype none

package pidpi_pkg;

  localparam int GAIN_W      = 16;
  localparam int IRANGE_W    = 24;
  localparam int ISUM_W      = 25;
  localparam int MAXOUT_W    = 15;
  localparam int DRIVE_W     = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOOP_MODE      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_RANGE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_OUTPUT     = 3'd5;

  // loop forms
  localparam logic MODE_POSITIONAL  = 1'b0;
  localparam logic MODE_INCREMENTAL = 1'b1;

  localparam logic [MAXOUT_W-1:0] MAX_OUTPUT_RESET = '1;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic                     loop_mode;
    logic [IRANGE_W-1:0]      integral_range;
    logic [MAXOUT_W-1:0]      max_output;
  } cfg_t;

endpackage

`default_nettype wire

/* sv/pidpi_if.sv */
// ----------------------------------------------------------------------------
// pidpi_if
// valid/ready channels of the pid core: samples in, drive out, register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface pidpi_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] measured;
  logic signed [SAMPLE_BITS-1:0] target;

  modport source (output valid, output measured, output target, input ready);
  modport sink   (input valid, input measured, input target, output ready);
endinterface

interface pidpi_out_if import pidpi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      saturated;

  modport source (output valid, output drive, output saturated, input ready);
  modport sink   (input valid, input drive, input saturated, output ready);
endinterface

interface pidpi_cfg_if import pidpi_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/pidpi_front.sv */
// ----------------------------------------------------------------------------
// pidpi_front
// input register, error and history update, integral clamp, multiplier operands
// ----------------------------------------------------------------------------
`default_nettype none

module pidpi_front import pidpi_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  localparam int EW    = SAMPLE_BITS + 1,
  localparam int OPP_W = SAMPLE_BITS + 2,
  localparam int OPD_W = SAMPLE_BITS + 3,
  localparam int OPI_W = (EW > ISUM_W) ? EW : ISUM_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [SAMPLE_BITS-1:0] measured,
  input  logic signed [SAMPLE_BITS-1:0] target,
  input  cfg_t                          cfg,
  output logic                          v_ops,
  output logic signed [OPP_W-1:0]       op_p,
  output logic signed [OPI_W-1:0]       op_i,
  output logic signed [OPD_W-1:0]       op_d
);

  localparam int IW = OPI_W + 1;
  localparam int MW = (EW > IRANGE_W) ? EW : IRANGE_W;

  logic                          v_in;
  logic signed [SAMPLE_BITS-1:0] meas_in;
  logic signed [SAMPLE_BITS-1:0] targ_in;

  logic signed [EW-1:0]          error_last;
  logic signed [SAMPLE_BITS-1:0] meas_last;
  logic signed [SAMPLE_BITS-1:0] meas_before_last;
  logic signed [ISUM_W-1:0]      integral_sum;

  logic signed [EW-1:0]    err;
  logic        [EW-1:0]    mag;
  logic signed [OPP_W-1:0] de;
  logic signed [OPD_W-1:0] dm;
  logic signed [IW-1:0]    isum_wide;
  logic signed [IW-1:0]    range_w;
  logic signed [IW-1:0]    isum_clamp;
  logic                    i_on;
  logic signed [OPP_W-1:0] op_p_next;
  logic signed [OPI_W-1:0] op_i_next;
  logic signed [OPD_W-1:0] op_d_next;

  always_comb begin
    err = EW'(targ_in) - EW'(meas_in);
    mag = err[EW-1] ? EW'(-err) : EW'(err);
    de  = OPP_W'(err) - OPP_W'(error_last);
    // 2*m0 - 3*m1 + m2
    dm  = (OPD_W'(meas_in) <<< 1) - (OPD_W'(meas_last) <<< 1) - OPD_W'(meas_last)
          + OPD_W'(meas_before_last);

    isum_wide = IW'(integral_sum) + IW'(err);
    range_w   = $signed(IW'(cfg.integral_range));
    if (isum_wide > range_w) begin
      isum_clamp = range_w;
    end else if (isum_wide < -range_w) begin
      isum_clamp = -range_w;
    end else begin
      isum_clamp = isum_wide;
    end
    // integral separation
    i_on = MW'(mag) <= MW'(cfg.integral_range);

    if (cfg.loop_mode == MODE_INCREMENTAL) begin
      op_p_next = de;
      op_i_next = OPI_W'(err);
      op_d_next = -dm;
    end else begin
      op_p_next = OPP_W'(err);
      op_i_next = i_on ? OPI_W'(isum_clamp) : '0;
      op_d_next = OPD_W'(de);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in             <= 1'b0;
      v_ops            <= 1'b0;
      error_last       <= '0;
      meas_last        <= '0;
      meas_before_last <= '0;
      integral_sum     <= '0;
    end else if (adv) begin
      v_in  <= in_valid;
      v_ops <= v_in;
      if (v_in) begin
        error_last       <= err;
        meas_last        <= meas_in;
        meas_before_last <= meas_last;
        if (cfg.loop_mode == MODE_POSITIONAL) begin
          integral_sum <= ISUM_W'(isum_clamp);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      meas_in <= measured;
      targ_in <= target;
    end
    if (adv && v_in) begin
      op_p <= op_p_next;
      op_i <= op_i_next;
      op_d <= op_d_next;
    end
  end

endmodule

`default_nettype wire

/* sv/pidpi_mult.sv */
// ----------------------------------------------------------------------------
// pidpi_mult
// gain products, then their sum scaled down by the gain fraction bits
// ----------------------------------------------------------------------------
`default_nettype none

module pidpi_mult import pidpi_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 8,
  localparam int EW    = SAMPLE_BITS + 1,
  localparam int OPP_W = SAMPLE_BITS + 2,
  localparam int OPD_W = SAMPLE_BITS + 3,
  localparam int OPI_W = (EW > ISUM_W) ? EW : ISUM_W,
  localparam int ACC_W = GAIN_W + ((OPD_W > OPI_W) ? OPD_W : OPI_W) + 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    v_ops,
  input  logic signed [OPP_W-1:0] op_p,
  input  logic signed [OPI_W-1:0] op_i,
  input  logic signed [OPD_W-1:0] op_d,
  input  cfg_t                    cfg,
  output logic                    v_sum,
  output logic signed [ACC_W-1:0] acc_sh
);

  localparam int PP_W = GAIN_W + OPP_W;
  localparam int PI_W = GAIN_W + OPI_W;
  localparam int PD_W = GAIN_W + OPD_W;

  logic                   v_prod;
  logic signed [PP_W-1:0] prod_p;
  logic signed [PI_W-1:0] prod_i;
  logic signed [PD_W-1:0] prod_d;
  logic signed [ACC_W-1:0] acc;

  // arithmetic shift rounds toward minus infinity
  assign acc = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_prod <= 1'b0;
      v_sum  <= 1'b0;
    end else if (adv) begin
      v_prod <= v_ops;
      v_sum  <= v_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v_ops) begin
      prod_p <= PP_W'(cfg.gain_p) * PP_W'(op_p);
      prod_i <= PI_W'(cfg.gain_i) * PI_W'(op_i);
      prod_d <= PD_W'(cfg.gain_d) * PD_W'(op_d);
    end
    if (adv && v_prod) begin
      acc_sh <= acc >>> GAIN_FRAC_BITS;
    end
  end

endmodule

`default_nettype wire

/* sv/pidpi_sat.sv */
// ----------------------------------------------------------------------------
// pidpi_sat
// output accumulation, symmetric saturation and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module pidpi_sat import pidpi_pkg::*; #(
  parameter int ACC_W = 37
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      v_sum,
  input  logic signed [ACC_W-1:0]   acc_sh,
  input  cfg_t                      cfg,
  output logic                      out_valid,
  output logic signed [DRIVE_W-1:0] drive,
  output logic                      saturated
);

  localparam int VW = ACC_W + 1;

  logic signed [DRIVE_W-1:0] output_accum;
  logic signed [VW-1:0]      val;
  logic signed [VW-1:0]      lim;
  logic signed [VW-1:0]      clamped;
  logic                      over_hi;
  logic                      over_lo;

  always_comb begin
    val = VW'(acc_sh);
    if (cfg.loop_mode == MODE_INCREMENTAL) begin
      val = val + VW'(output_accum);
    end
    lim     = $signed(VW'(cfg.max_output));
    over_hi = val > lim;
    over_lo = val < -lim;
    if (over_hi) begin
      clamped = lim;
    end else if (over_lo) begin
      clamped = -lim;
    end else begin
      clamped = val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      output_accum <= '0;
    end else if (adv) begin
      out_valid <= v_sum;
      if (v_sum) begin
        output_accum <= clamped[DRIVE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v_sum) begin
      drive     <= clamped[DRIVE_W-1:0];
      saturated <= over_hi | over_lo;
    end
  end

endmodule

`default_nettype wire

/* sv/pid_position_incremental_step_core.sv */
// ----------------------------------------------------------------------------
// pid_position_incremental_step_core
// fixed-point pid step, positional or incremental form, saturated drive
// ----------------------------------------------------------------------------
// Each sample transfer (measured, target) yields exactly one result transfer
// (drive, saturated), in order. The core is a five-register pipeline: input
// register, operand register, product register, scaled-sum register and
// result register, so one sample is taken every clock cycle while the
// output side does not stall. The two feedback paths, the integral
// add-and-clamp in the operand stage and the output accumulate-and-clamp
// in the result stage, each close within their own stage. A stall on the
// result side freezes the whole pipeline; sample.ready follows the result
// register. Registers are written through cfg, always ready; the user must
// write them only while no sample is in flight, which the block does not
// enforce. An index beyond the list is ignored. Gains are signed Q8.8 and
// each weighted sum is scaled by an arithmetic shift, rounding toward minus
// infinity. There is no start-up clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_position_incremental_step_core import pidpi_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  pidpi_in_if.sink    sample,
  pidpi_out_if.source result,
  pidpi_cfg_if.sink   cfg
);

  localparam int EW    = SAMPLE_BITS + 1;
  localparam int OPP_W = SAMPLE_BITS + 2;
  localparam int OPD_W = SAMPLE_BITS + 3;
  localparam int OPI_W = (EW > ISUM_W) ? EW : ISUM_W;
  localparam int ACC_W = GAIN_W + ((OPD_W > OPI_W) ? OPD_W : OPI_W) + 2;

  cfg_t                    cfg_regs;
  logic                    adv;
  logic                    v_ops;
  logic signed [OPP_W-1:0] op_p;
  logic signed [OPI_W-1:0] op_i;
  logic signed [OPD_W-1:0] op_d;
  logic                    v_sum;
  logic signed [ACC_W-1:0] acc_sh;

  // whole pipeline moves unless a finished result is waiting
  assign adv          = !result.valid || result.ready;
  assign sample.ready = adv;
  assign cfg.ready    = 1'b1;

  // register file, written on a cfg transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.gain_p         <= '0;
      cfg_regs.gain_i         <= '0;
      cfg_regs.gain_d         <= '0;
      cfg_regs.loop_mode      <= MODE_POSITIONAL;
      cfg_regs.integral_range <= '0;
      cfg_regs.max_output     <= MAX_OUTPUT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_GAIN_P:         cfg_regs.gain_p         <= cfg.data[GAIN_W-1:0];
        REG_GAIN_I:         cfg_regs.gain_i         <= cfg.data[GAIN_W-1:0];
        REG_GAIN_D:         cfg_regs.gain_d         <= cfg.data[GAIN_W-1:0];
        REG_LOOP_MODE:      cfg_regs.loop_mode      <= cfg.data[0];
        REG_INTEGRAL_RANGE: cfg_regs.integral_range <= cfg.data[IRANGE_W-1:0];
        REG_MAX_OUTPUT:     cfg_regs.max_output     <= cfg.data[MAXOUT_W-1:0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // error, history and integral, then the three multiplier operands
  pidpi_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (sample.valid),
    .measured (sample.measured),
    .target   (sample.target),
    .cfg      (cfg_regs),
    .v_ops    (v_ops),
    .op_p     (op_p),
    .op_i     (op_i),
    .op_d     (op_d)
  );

  // gain products and scaled sum
  pidpi_mult #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_mult (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .v_ops  (v_ops),
    .op_p   (op_p),
    .op_i   (op_i),
    .op_d   (op_d),
    .cfg    (cfg_regs),
    .v_sum  (v_sum),
    .acc_sh (acc_sh)
  );

  // accumulate in incremental form, saturate, hold the result
  pidpi_sat #(
    .ACC_W (ACC_W)
  ) u_sat (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .v_sum     (v_sum),
    .acc_sh    (acc_sh),
    .cfg       (cfg_regs),
    .out_valid (result.valid),
    .drive     (result.drive),
    .saturated (result.saturated)
  );

`ifndef SYNTHESIS
  // reset leaves no result pending
  a_reset_empties: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  // a stalled sum stage keeps its item
  a_sum_holds: assert property (@(posedge clk) disable iff (rst)
    (v_sum && !adv) |=> (v_sum && $stable(acc_sh)))
    else $error("scaled sum lost during stall");

  // a new result only comes out of a filled sum stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !$past(result.valid)) |-> $past(v_sum))
    else $error("result appeared without a sum");
`endif

endmodule

`default_nettype wire

/* tb/pid_drive_checker.sv */
// ----------------------------------------------------------------------------
// pid_drive_checker
// watches the sample, result and register channels of the pid core, works
// out the drive value of every accepted sample and compares it in order
// ----------------------------------------------------------------------------
module pid_drive_checker import pidpi_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic signed [15:0]          measured,
  input  logic signed [15:0]          target,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [DRIVE_W-1:0]   drive,
  input  logic                        saturated,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  output int                          mismatch_count,
  output int                          drives_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 8;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      saturated;
  } drive_rec_t;

  // register copies
  logic signed [GAIN_W-1:0] kp, ki, kd;
  logic                     form;
  logic [IRANGE_W-1:0]      irange;
  logic [MAXOUT_W-1:0]      drive_limit;

  // loop history
  logic signed [16:0]         err_prev;
  logic signed [15:0]         meas_prev, meas_prev2;
  logic signed [ISUM_W-1:0]   isum;
  logic signed [DRIVE_W-1:0]  drive_prev;

  drive_rec_t drive_queue[$];

  initial begin
    mismatch_count = 0;
    drives_owed    = 0;
  end

  function automatic drive_rec_t next_drive(logic signed [15:0] meas, logic signed [15:0] tgt);
    longint m0, err, mag, lim, span, acc, val, isum_next, dm;
    drive_rec_t r;
    m0  = meas;
    err = longint'(tgt) - m0;
    lim = longint'(drive_limit);
    span = longint'(irange);
    r.saturated = 1'b0;
    if (form == MODE_POSITIONAL) begin
      mag = (err < 0) ? -err : err;
      isum_next = longint'(isum) + err;
      if (isum_next > span) isum_next = span;
      else if (isum_next < -span) isum_next = -span;
      isum = isum_next[ISUM_W-1:0];
      acc = longint'(kp) * err + longint'(kd) * (err - longint'(err_prev));
      if (mag <= span) acc += longint'(ki) * isum_next;
      val = acc >>> FRAC_BITS;
    end else begin
      // weighted difference of the three newest measurements, newest weighted twice
      dm  = 2 * m0 - 3 * longint'(meas_prev) + longint'(meas_prev2);
      acc = longint'(kp) * (err - longint'(err_prev)) + longint'(ki) * err
            - longint'(kd) * dm;
      val = longint'(drive_prev) + (acc >>> FRAC_BITS);
    end
    if (val > lim) begin
      val = lim;
      r.saturated = 1'b1;
    end else if (val < -lim) begin
      val = -lim;
      r.saturated = 1'b1;
    end
    drive_prev = val[DRIVE_W-1:0];
    err_prev   = err[16:0];
    meas_prev2 = meas_prev;
    meas_prev  = meas;
    r.drive    = val[DRIVE_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    drive_rec_t want;
    if (rst) begin
      kp = '0; ki = '0; kd = '0;
      form = MODE_POSITIONAL;
      irange = '0;
      drive_limit = MAX_OUTPUT_RESET;
      err_prev = '0; meas_prev = '0; meas_prev2 = '0;
      isum = '0; drive_prev = '0;
      drive_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_P:         kp = cfg_data[GAIN_W-1:0];
          REG_GAIN_I:         ki = cfg_data[GAIN_W-1:0];
          REG_GAIN_D:         kd = cfg_data[GAIN_W-1:0];
          REG_LOOP_MODE:      form = cfg_data[0];
          REG_INTEGRAL_RANGE: irange = cfg_data[IRANGE_W-1:0];
          REG_MAX_OUTPUT:     drive_limit = cfg_data[MAXOUT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (drive_queue.size() == 0) begin
          $display("%0t unexpected result transfer: drive %0d saturated %0b",
                   $time, drive, saturated);
          mismatch_count++;
        end else begin
          want = drive_queue.pop_front();
          if (drive !== want.drive) begin
            $display("%0t drive mismatch: expected %0d actual %0d",
                     $time, $signed(want.drive), drive);
            mismatch_count++;
          end
          if (saturated !== want.saturated) begin
            $display("%0t saturated mismatch: expected %0b actual %0b",
                     $time, want.saturated, saturated);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) drive_queue.push_back(next_drive(measured, target));
    end
    drives_owed = drive_queue.size();
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// pid core test: directed and random sample streams under several register
// settings, random idling on both channels and one long result stall
// ----------------------------------------------------------------------------
module testbench import pidpi_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES    = 6;
  localparam int LATENCY_CYCLES  = 8;     // five pipeline stages plus margin
  localparam int HOLD_CYCLES     = 300;   // long result stall, fills the pipe
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int TIMEOUT_NS      = 1_000_000;

  // indexes past the register list, writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  logic clk;
  logic rst;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int mismatch_count;
  int drives_owed;

  pidpi_in_if #(.SAMPLE_BITS(16)) smp_ch ();
  pidpi_out_if                    res_ch ();
  pidpi_cfg_if                    cfg_ch ();

  pid_position_incremental_step_core DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (smp_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  pid_drive_checker drive_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (smp_ch.valid),
    .in_ready       (smp_ch.ready),
    .measured       (smp_ch.measured),
    .target         (smp_ch.target),
    .out_valid      (res_ch.valid),
    .out_ready      (res_ch.ready),
    .drive          (res_ch.drive),
    .saturated      (res_ch.saturated),
    .cfg_valid      (cfg_ch.valid),
    .cfg_ready      (cfg_ch.ready),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .mismatch_count (mismatch_count),
    .drives_owed    (drives_owed)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // hard stop in case the core hangs
  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random back-pressure, or a long stall when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // one register transfer, with valid dropped again before the task returns
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // all six registers; unused upper data bits carry junk
  task automatic program_regs(input logic signed [15:0] p, input logic signed [15:0] i,
                              input logic signed [15:0] d, input logic mode,
                              input logic [IRANGE_W-1:0] range,
                              input logic [MAXOUT_W-1:0] limit);
    write_reg(REG_GAIN_P, {8'($urandom_range(255)), p});
    write_reg(REG_GAIN_I, {8'($urandom_range(255)), i});
    write_reg(REG_GAIN_D, {8'($urandom_range(255)), d});
    write_reg(REG_LOOP_MODE, {23'($urandom), mode});
    write_reg(REG_INTEGRAL_RANGE, range);
    write_reg(REG_MAX_OUTPUT, {9'($urandom_range(511)), limit});
  endtask

  // sample transfer; valid stays high afterwards unless the next call idles
  task automatic send_sample(input logic signed [15:0] m, input logic signed [15:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      smp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    smp_ch.valid    <= 1'b1;
    smp_ch.measured <= m;
    smp_ch.target   <= t;
    @(posedge clk);
    while (!smp_ch.ready) @(posedge clk);
  endtask

  // stop offering and wait until every drive value is back and the pipe is quiet
  task automatic end_burst();
    smp_ch.valid <= 1'b0;
    @(posedge clk);
    while (drives_owed != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] clip16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(3))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_gain();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1024) - 512);   // moderate gain, +/- 2.0
    endcase
  endfunction

  function automatic logic [IRANGE_W-1:0] pick_range();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return IRANGE_W'($urandom);
      default: return IRANGE_W'($urandom_range(70000));
    endcase
  endfunction

  function automatic logic [MAXOUT_W-1:0] pick_limit();
    case ($urandom_range(5))
      0:       return '0;
      1:       return MAX_OUTPUT_RESET;
      default: return MAXOUT_W'($urandom_range(32767, 1));
    endcase
  endfunction

  // mostly a measurement hovering around a setpoint that moves now and then,
  // the rest fully random samples and extremes
  task automatic send_random_items(input int count);
    int setpoint;
    int span;
    int m;
    int t;
    int kind;
    setpoint = $signed(16'($urandom));
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(15) == 0) setpoint = $signed(16'($urandom));
      kind = $urandom_range(99);
      if (kind < 70) begin
        span = 1 << $urandom_range(12, 2);
        t = setpoint;
        m = setpoint + int'($urandom_range(2 * span)) - span;
      end else if (kind < 90) begin
        m = $signed(16'($urandom));
        t = $signed(16'($urandom));
      end else begin
        m = pick_extreme();
        t = pick_extreme();
      end
      send_sample(clip16(m), clip16(t));
    end
  endtask

  initial begin
    rst             = 1'b1;
    smp_ch.valid    = 1'b0;
    smp_ch.measured = '0;
    smp_ch.target   = '0;
    res_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    hold_cycles     = 0;
    // first regime: sender idles a quarter, receiver three quarters
    send_idle_pct   = 24;
    recv_idle_pct   = 74;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // positional form: gains 1.0, 0.5, 0.25 and a modest integral range
    program_regs(16'sh0100, 16'sh0080, 16'sh0040, MODE_POSITIONAL, 24'd1000, 15'd32767);
    send_sample(0, 0);
    send_sample(0, 100);
    send_sample(50, 100);
    send_sample(0, 1000);          // error right at the range, integral still counts
    send_sample(0, 1001);          // just outside, integral dropped
    send_sample(0, -1000);
    send_sample(0, 2000);
    send_sample(-32768, 32767);    // largest positive error
    send_sample(32767, -32768);    // largest negative error
    send_sample(-1, -1);
    send_sample(32767, 32767);
    end_burst();

    // gain extremes with the widest integral range
    program_regs(16'sh8000, 16'sh7fff, 16'sh8000, MODE_POSITIONAL, '1, 15'd32767);
    send_sample(0, 1);
    send_sample(1, 0);
    send_sample(5, -5);
    end_burst();

    // incremental form; history carries over from the positional items
    program_regs(16'sh0100, 16'sh0020, 16'sh0080, MODE_INCREMENTAL, 24'd500, 15'd20000);
    send_sample(0, 100);
    send_sample(10, 100);
    send_sample(40, 100);
    send_sample(80, 100);
    send_sample(-32768, 32767);
    send_sample(32767, -32768);
    end_burst();

    // zero integral range and zero drive limit
    program_regs(16'sh0100, 16'sh0100, 16'sh0100, MODE_POSITIONAL, '0, '0);
    send_sample(0, 50);
    send_sample(-32768, 32767);
    end_burst();
    write_reg(REG_LOOP_MODE, {23'd0, MODE_INCREMENTAL});
    send_sample(10, -10);
    end_burst();

    // writes past the register list must leave everything alone
    write_reg(REG_MAX_OUTPUT, CFG_DATA_W'(MAX_OUTPUT_RESET));
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, 24'h5a5a5a);
    send_sample(0, 300);
    send_sample(-200, 300);
    end_burst();

    // random settings and sample streams
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES / 3) begin
        send_idle_pct = 74;
        recv_idle_pct = 24;
      end else if (ph == 2 * PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_regs(pick_gain(), pick_gain(), pick_gain(), 1'($urandom_range(1)),
                   pick_range(), pick_limit());
      // one long stall on the result side while samples keep coming
      if (ph == 1) hold_cycles = HOLD_CYCLES;
      send_random_items(ITEMS_PER_PHASE);
      end_burst();
    end

    repeat (LATENCY_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
